### src/assert_macros.svh
// Assertion helpers included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bccc check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bccc check failed");

`endif

### src/bccc_pkg.sv
`timescale 1ns / 1ps

package bccc_pkg;

  localparam int GainW    = 32;
  localparam int AngW     = 17;
  localparam int RateW    = 16;
  localparam int CntW     = 16;
  localparam int LineW    = 8;
  localparam int DutyW    = 13;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Serial multiplier: one multiplier bit per cycle.
  localparam int MulW    = 32;
  localparam int ProdW   = 64;
  localparam int MulCntW = $clog2(MulW + 1);

  // Serial divider by a small constant: one quotient bit per cycle.
  localparam int DivRemW = 8;
  localparam int DivCntW = $clog2(ProdW + 1);

  localparam int ErrW   = 18;
  localparam int E3W    = ErrW + 2;
  localparam int FiltW  = 32;
  localparam int E7W    = FiltW + 3;
  localparam int NumW   = 36;
  localparam int IntegW = 32;
  localparam int LdiffW = LineW + 1;
  localparam int LnW    = 28;
  localparam int DrvW   = 42;

  localparam logic [DivRemW-1:0] FilterDiv = 8'd10;
  localparam logic [DivRemW-1:0] IntegDiv  = 8'd200;

  localparam int UpShift = 24;
  localparam int SpShift = 28;
  localparam logic signed [ProdW-1:0] UpBias = 64'sh0000_0000_00FF_FFFF;
  localparam logic signed [ProdW-1:0] SpBias = 64'sh0000_0000_0FFF_FFFF;

  localparam logic signed [IntegW-1:0] IntegMax = 32'sd12288000;
  localparam logic signed [DrvW-1:0]   DriveMax = 42'sd7000;
  localparam logic signed [AngW-1:0]   RollStop = 17'sd13056;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAL_KP  = 3'd0,
    REG_BAL_KD  = 3'd1,
    REG_MID     = 3'd2,
    REG_SPD_KP  = 3'd3,
    REG_TARGET  = 3'd4,
    REG_LINE_KP = 3'd5,
    REG_LINE_KD = 3'd6,
    REG_RUN     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0] balance_gain_p;
    logic signed [GainW-1:0] balance_gain_d;
    logic signed [AngW-1:0]  mid_angle;
    logic signed [GainW-1:0] speed_gain_p;
    logic signed [CntW-1:0]  target_speed;
    logic signed [CntW-1:0]  line_gain_p;
    logic signed [CntW-1:0]  line_gain_d;
    logic                    run_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    balance_gain_p: 32'sd18087936,
    balance_gain_d: -32'sd91750,
    mid_angle:      17'sd2560,
    speed_gain_p:   32'sd301466,
    target_speed:   16'sd0,
    line_gain_p:    16'sd35,
    line_gain_d:    -16'sd12,
    run_enable:     1'b0
  };

  typedef struct packed {
    logic signed [AngW-1:0]  pitch_angle;
    logic signed [RateW-1:0] pitch_rate;
    logic signed [AngW-1:0]  roll_angle;
    logic signed [CntW-1:0]  left_count;
    logic signed [CntW-1:0]  right_count;
    logic signed [LineW-1:0] line_offset;
  } sample_t;

  typedef struct packed {
    logic [DutyW-1:0] left_duty;
    logic             left_reverse;
    logic [DutyW-1:0] right_duty;
    logic             right_reverse;
    logic             fallen;
  } result_t;

endpackage

### src/bccc_if.sv
`timescale 1ns / 1ps

interface bccc_in_if import bccc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AngW-1:0]  pitch_angle;
  logic signed [RateW-1:0] pitch_rate;
  logic signed [AngW-1:0]  roll_angle;
  logic signed [CntW-1:0]  left_count;
  logic signed [CntW-1:0]  right_count;
  logic signed [LineW-1:0] line_offset;

  modport source (output valid, pitch_angle, pitch_rate, roll_angle, left_count,
                  right_count, line_offset, input ready);
  modport sink (input valid, pitch_angle, pitch_rate, roll_angle, left_count,
                right_count, line_offset, output ready);
endinterface

interface bccc_out_if import bccc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] left_duty;
  logic             left_reverse;
  logic [DutyW-1:0] right_duty;
  logic             right_reverse;
  logic             fallen;

  modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                  fallen, input ready);
  modport sink (input valid, left_duty, left_reverse, right_duty, right_reverse,
                fallen, output ready);
endinterface

interface bccc_cfg_if import bccc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/balance_car_cascade_controller_unit.sv
`timescale 1ns / 1ps

//  Channel   Direction   Contents
//  in_i      sink        pitch, pitch rate, roll, two encoder counts, line offset
//  out_o     source      left/right duty and reverse bits, fallen flag
//  cfg_i     sink        register index and write data, always ready
//
// One tick runs from acceptance to result through six passes of the bit-serial
// multiplier, two passes of the serial divider by a constant, and the setup,
// truncation and summing states around them.
// The sample side accepts a new transaction only while the sequencer is idle.
// The result sits in an output register, so a stalled sink does not stop the
// next tick from starting; the sequencer waits only when that register is full.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the filter, integral, line history, fall flag and held directions.

`include "assert_macros.svh"

module balance_car_cascade_controller_unit import bccc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bccc_in_if.sink      in_i,
  bccc_out_if.source   out_o,
  bccc_cfg_if.sink     cfg_i
);

  cfg_t    cfg_q;
  sample_t smp;
  result_t res, out_q;
  logic    res_valid, res_ready, out_valid_q;

  // Configuration: every write transaction is taken at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BAL_KP:  cfg_q.balance_gain_p <= cfg_i.data;
        REG_BAL_KD:  cfg_q.balance_gain_d <= cfg_i.data;
        REG_MID:     cfg_q.mid_angle      <= cfg_i.data[AngW-1:0];
        REG_SPD_KP:  cfg_q.speed_gain_p   <= cfg_i.data;
        REG_TARGET:  cfg_q.target_speed   <= cfg_i.data[CntW-1:0];
        REG_LINE_KP: cfg_q.line_gain_p    <= cfg_i.data[CntW-1:0];
        REG_LINE_KD: cfg_q.line_gain_d    <= cfg_i.data[CntW-1:0];
        REG_RUN:     cfg_q.run_enable     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign smp.pitch_angle = in_i.pitch_angle;
  assign smp.pitch_rate  = in_i.pitch_rate;
  assign smp.roll_angle  = in_i.roll_angle;
  assign smp.left_count  = in_i.left_count;
  assign smp.right_count = in_i.right_count;
  assign smp.line_offset = in_i.line_offset;

  bccc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .smp_valid_i (in_i.valid),
    .smp_ready_o (in_i.ready),
    .smp_i       (smp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: filled by the sequencer, drained by the sink.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_duty     = out_q.left_duty;
  assign out_o.left_reverse  = out_q.left_reverse;
  assign out_o.right_duty    = out_q.right_duty;
  assign out_o.right_reverse = out_q.right_reverse;
  assign out_o.fallen        = out_q.fallen;

  // The drive limit holds on every delivered result.
  `BCCC_ASSERT_SAME(a_duty_limit, clk_i, rst_ni, out_o.valid,
    (out_o.left_duty <= DutyW'(7000)) && (out_o.right_duty <= DutyW'(7000)))
  // A fall stops both motors.
  `BCCC_ASSERT_SAME(a_fall_stops, clk_i, rst_ni, out_o.valid && out_o.fallen,
    (out_o.left_duty == '0) && (out_o.right_duty == '0))
  // An accepted sample keeps the sequencer busy in the following cycle.
  `BCCC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready,
    !in_i.ready)
  // A result computed while stopped carries no drive.
  `BCCC_ASSERT_SAME(a_stop_no_drive, clk_i, rst_ni,
    res_valid && !cfg_q.run_enable, (res.left_duty == '0) && (res.right_duty == '0))

endmodule

### src/bccc_smul.sv
`timescale 1ns / 1ps

// Signed shift-add multiplier, one multiplier bit per cycle.
module bccc_smul import bccc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  logic [MulCntW-1:0] cnt_q;
  logic               done_q;
  logic [ProdW-1:0]   mcand_q;
  logic [MulW-1:0]    mplier_q;
  logic [ProdW-1:0]   prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= MulCntW'(MulW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - MulCntW'(1);
        done_q <= (cnt_q == MulCntW'(1));
      end
    end
  end

  // The last multiplier bit carries negative weight.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= {{(ProdW-MulW){a_i[MulW-1]}}, a_i};
      mplier_q <= b_i;
      prod_q   <= '0;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        if (cnt_q == MulCntW'(1)) begin
          prod_q <= prod_q - mcand_q;
        end else begin
          prod_q <= prod_q + mcand_q;
        end
      end
      mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MulW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

### src/bccc_udiv.sv
`timescale 1ns / 1ps

// Restoring divider of an unsigned word by a small constant, one quotient bit per cycle.
module bccc_udiv import bccc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ProdW-1:0]   dvd_i,
  input  logic [DivRemW-1:0] dsr_i,
  output logic               done_o,
  output logic [ProdW-1:0]   quo_o
);

  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [ProdW-1:0]   dvd_q;
  logic [DivRemW-1:0] rem_q;
  logic [DivRemW-1:0] dsr_q;
  logic [DivRemW:0]   trial;
  logic [DivRemW:0]   diff;
  logic               ge;

  assign trial = {rem_q, dvd_q[ProdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DivCntW'(ProdW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - DivCntW'(1);
        done_q <= (cnt_q == DivCntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      rem_q <= '0;
      dsr_q <= dsr_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DivRemW-1:0] : trial[DivRemW-1:0];
      dvd_q <= {dvd_q[ProdW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

### src/bccc_core.sv
`timescale 1ns / 1ps

// Tick sequencer: walks one sample through the shared serial multiplier and divider.
module bccc_core import bccc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    smp_valid_i,
  output logic    smp_ready_o,
  input  sample_t smp_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0_0000_0000_0001,
    ST_PREP  = 13'b0_0000_0000_0010,
    ST_UP_P  = 13'b0_0000_0000_0100,
    ST_UP_D  = 13'b0_0000_0000_1000,
    ST_DIV_E = 13'b0_0000_0001_0000,
    ST_SP_E  = 13'b0_0000_0010_0000,
    ST_SP_I  = 13'b0_0000_0100_0000,
    ST_DIV_I = 13'b0_0000_1000_0000,
    ST_LN_P  = 13'b0_0001_0000_0000,
    ST_LN_D  = 13'b0_0010_0000_0000,
    ST_TRUNC = 13'b0_0100_0000_0000,
    ST_SUM   = 13'b0_1000_0000_0000,
    ST_OUT   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic               mul_start, mul_done, div_start, div_done;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   prod, quo, div_dvd;
  logic [DivRemW-1:0] div_dsr;

  sample_t                  smp_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [LdiffW-1:0] ldiff_q;
  logic signed [E3W-1:0]    e3_q;
  logic signed [E7W-1:0]    e7_q;
  logic signed [NumW-1:0]   num_q;
  logic                     num_neg_q;
  logic                     prod_neg_q;
  logic signed [ProdW-1:0]  up_acc_q, sp_acc_q;
  logic signed [FiltW-1:0]  filt_q;
  logic signed [IntegW-1:0] integ_q, integ_tmp_q;
  logic signed [LnW-1:0]    ln_q;
  logic signed [DrvW-1:0]   up_q, sp_q, left_q, right_q;
  logic signed [LineW-1:0]  prev_line_q;
  logic                     fallen_last_q;
  logic [1:0]               held_q;

  logic signed [ErrW-1:0]   pdiff_c, err_c;
  logic signed [LdiffW-1:0] ldiff_c;
  logic [NumW-1:0]          num_mag;
  logic [ProdW-1:0]         prod_mag;
  logic signed [FiltW-1:0]  e_c;
  logic signed [ProdW-1:0]  quo_s;
  logic signed [IntegW:0]   isum;
  logic signed [IntegW-1:0] integ_c;
  logic signed [ProdW-1:0]  up_b, sp_b, up_sh, sp_sh;
  logic signed [DrvW-1:0]   lim_l, lim_r, abs_l, abs_r;
  logic                     fallen_c, active_c;
  logic [1:0]               dirs_c;

  bccc_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  bccc_udiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dsr_i   (div_dsr),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign pdiff_c = {cfg_i.mid_angle[AngW-1], cfg_i.mid_angle}
                 - {smp_q.pitch_angle[AngW-1], smp_q.pitch_angle};
  assign err_c = {{2{smp_q.left_count[CntW-1]}}, smp_q.left_count}
               + {{2{smp_q.right_count[CntW-1]}}, smp_q.right_count}
               - {{2{cfg_i.target_speed[CntW-1]}}, cfg_i.target_speed};
  assign ldiff_c = {smp_q.line_offset[LineW-1], smp_q.line_offset}
                 - {prev_line_q[LineW-1], prev_line_q};

  assign num_mag  = num_q[NumW-1] ? NumW'(-num_q) : num_q;
  assign prod_mag = prod[ProdW-1] ? (~prod + ProdW'(1)) : prod;
  assign e_c      = num_neg_q ? FiltW'(-$signed(quo[FiltW-1:0])) : $signed(quo[FiltW-1:0]);
  assign quo_s    = prod_neg_q ? -$signed(quo) : $signed(quo);

  // Integral update: clamp, then clear after a fall or while stopped.
  always_comb begin
    isum = {integ_q[IntegW-1], integ_q} + {filt_q[FiltW-1], filt_q};
    if (isum > $signed({IntegMax[IntegW-1], IntegMax})) begin
      integ_c = IntegMax;
    end else if (isum < -$signed({IntegMax[IntegW-1], IntegMax})) begin
      integ_c = -IntegMax;
    end else begin
      integ_c = isum[IntegW-1:0];
    end
    if (fallen_last_q || !cfg_i.run_enable) begin
      integ_c = '0;
    end
  end

  // Truncation toward zero: bias negative values before the arithmetic shift.
  assign up_b  = up_acc_q + (up_acc_q[ProdW-1] ? UpBias : '0);
  assign sp_b  = sp_acc_q + (sp_acc_q[ProdW-1] ? SpBias : '0);
  assign up_sh = up_b >>> UpShift;
  assign sp_sh = sp_b >>> SpShift;

  always_comb begin
    lim_l = left_q;
    if (left_q > DriveMax) lim_l = DriveMax;
    if (left_q < -DriveMax) lim_l = -DriveMax;
    lim_r = right_q;
    if (right_q > DriveMax) lim_r = DriveMax;
    if (right_q < -DriveMax) lim_r = -DriveMax;
  end

  assign abs_l    = lim_l[DrvW-1] ? -lim_l : lim_l;
  assign abs_r    = lim_r[DrvW-1] ? -lim_r : lim_r;
  assign fallen_c = (smp_q.roll_angle >= RollStop) || (smp_q.roll_angle <= -RollStop);
  assign active_c = cfg_i.run_enable && !fallen_c;
  assign dirs_c   = {(lim_r[DrvW-1] || (lim_r == '0)), (lim_l[DrvW-1] || (lim_l == '0))};

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = cfg_i.balance_gain_p;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = {{(ProdW-NumW){1'b0}}, num_mag};
    div_dsr   = FilterDiv;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        mul_start = 1'b1;
        mul_b     = {{(MulW-ErrW){pdiff_c[ErrW-1]}}, pdiff_c};
        state_d   = ST_UP_P;
      end
      ST_UP_P: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = cfg_i.balance_gain_d;
          mul_b     = {{(MulW-RateW){smp_q.pitch_rate[RateW-1]}}, smp_q.pitch_rate};
          state_d   = ST_UP_D;
        end
      end
      ST_UP_D: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = cfg_i.speed_gain_p;
          mul_b     = e_c;
          state_d   = ST_SP_E;
        end
      end
      ST_SP_E: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = cfg_i.speed_gain_p;
          mul_b     = integ_tmp_q;
          state_d   = ST_SP_I;
        end
      end
      ST_SP_I: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = prod_mag;
          div_dsr   = IntegDiv;
          state_d   = ST_DIV_I;
        end
      end
      ST_DIV_I: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = {{(MulW-CntW){cfg_i.line_gain_p[CntW-1]}}, cfg_i.line_gain_p};
          mul_b     = {{(MulW-LineW){smp_q.line_offset[LineW-1]}}, smp_q.line_offset};
          state_d   = ST_LN_P;
        end
      end
      ST_LN_P: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = {{(MulW-CntW){cfg_i.line_gain_d[CntW-1]}}, cfg_i.line_gain_d};
          mul_b     = {{(MulW-LdiffW){ldiff_q[LdiffW-1]}}, ldiff_q};
          state_d   = ST_LN_D;
        end
      end
      ST_LN_D: begin
        if (mul_done) state_d = ST_TRUNC;
      end
      ST_TRUNC: state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      filt_q        <= '0;
      integ_q       <= '0;
      prev_line_q   <= '0;
      fallen_last_q <= 1'b0;
      held_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV_E && div_done) filt_q <= e_c;
      if (state_q == ST_SP_E && mul_done) integ_q <= integ_tmp_q;
      if (state_q == ST_OUT && res_ready_i) begin
        prev_line_q   <= smp_q.line_offset;
        fallen_last_q <= fallen_c;
        if (active_c) held_q <= dirs_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (smp_valid_i) smp_q <= smp_i;
      end
      ST_PREP: begin
        err_q   <= err_c;
        ldiff_q <= ldiff_c;
      end
      ST_UP_P: begin
        e3_q <= {{2{err_q[ErrW-1]}}, err_q} + {err_q[ErrW-1], err_q, 1'b0};
        e7_q <= {filt_q, 3'b000} - {{3{filt_q[FiltW-1]}}, filt_q};
        if (mul_done) up_acc_q <= $signed(prod);
      end
      ST_UP_D: begin
        num_q <= {{(NumW-E3W-12){e3_q[E3W-1]}}, e3_q, 12'd0}
               + {{(NumW-E7W){e7_q[E7W-1]}}, e7_q};
        if (mul_done) begin
          up_acc_q  <= up_acc_q + {prod[ProdW-9:0], 8'd0};
          num_neg_q <= num_q[NumW-1];
        end
      end
      ST_SP_E: begin
        integ_tmp_q <= integ_c;
        if (mul_done) sp_acc_q <= $signed(prod);
      end
      ST_SP_I: begin
        if (mul_done) prod_neg_q <= prod[ProdW-1];
      end
      ST_DIV_I: begin
        if (div_done) sp_acc_q <= sp_acc_q + quo_s;
      end
      ST_LN_P: begin
        if (mul_done) ln_q <= $signed(prod[LnW-1:0]);
      end
      ST_LN_D: begin
        if (mul_done) ln_q <= ln_q + $signed(prod[LnW-1:0]);
      end
      ST_TRUNC: begin
        up_q <= up_sh[DrvW-1:0];
        sp_q <= sp_sh[DrvW-1:0];
      end
      ST_SUM: begin
        left_q  <= up_q + sp_q + {{(DrvW-LnW){ln_q[LnW-1]}}, ln_q};
        right_q <= up_q + sp_q - {{(DrvW-LnW){ln_q[LnW-1]}}, ln_q};
      end
      default: ;
    endcase
  end

  assign smp_ready_o         = (state_q == ST_IDLE);
  assign res_valid_o         = (state_q == ST_OUT);
  assign res_o.left_duty     = active_c ? abs_l[DutyW-1:0] : '0;
  assign res_o.right_duty    = active_c ? abs_r[DutyW-1:0] : '0;
  assign res_o.left_reverse  = active_c ? dirs_c[0] : held_q[0];
  assign res_o.right_reverse = active_c ? dirs_c[1] : held_q[1];
  assign res_o.fallen        = fallen_c;

endmodule
